// ===== hdl/maglev_table_build_and_lookup_defines.svh =====
// Assertion macros used by the Maglev table top level.
`ifndef MAGLEV_TABLE_BUILD_AND_LOOKUP_DEFINES_SVH
`define MAGLEV_TABLE_BUILD_AND_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTBL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mtbl_pkg.sv =====
// Package with constants, command codes and status type of the Maglev table.
package mtbl_pkg;

    localparam int TABLE_DEPTH        = 4096;
    localparam int MAX_NODES          = 16;
    localparam int DEFAULT_TABLE_SIZE = 4093;

    localparam int ADDR_W     = $clog2(TABLE_DEPTH);
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int NODE_IDX_W = $clog2(MAX_NODES);
    localparam int NODE_CNT_W = NODE_IDX_W + 1;
    localparam int FACTOR_W   = 7;
    localparam int REM_STEPS  = 32;
    localparam int REM_CNT_W  = $clog2(REM_STEPS);

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_BATCH,
        OP_PR_DIV,
        OP_PR_NEXT,
        OP_PR_YES,
        OP_PR_NO,
        OP_DUP_INIT,
        OP_DUP_STEP,
        OP_OFF_DIV,
        OP_OFF_SAVE,
        OP_SKIP_DIV,
        OP_SKIP_SAVE,
        OP_BUILD_EMPTY,
        OP_CLR_INIT,
        OP_CLR_STEP,
        OP_B_LOAD,
        OP_B_RD,
        OP_B_CHK,
        OP_B_DONE,
        OP_LK_DIV,
        OP_LK_RD,
        OP_OUT_HIT,
        OP_OUT_MISS
    } dp_op_t;

    typedef struct packed {
        logic is_lookup;
        logic last;
        logic loading;
        logic table_ok;
        logic v_lt2;
        logic v_eq2;
        logic v_even;
        logic f_sq_gt;
        logic rem_done;
        logic rem_zero;
        logic keep;
        logic j_end;
        logic count_full;
        logic count_zero;
        logic clr_last;
        logic filled_hit;
        logic fill_last;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== hdl/mtbl_rem.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo a 13-bit divisor.
module mtbl_rem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 dividend,
    input  logic [mtbl_pkg::SIZE_W-1:0] divisor,
    output logic                        done,
    output logic [mtbl_pkg::SIZE_W-1:0] remainder
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [mtbl_pkg::REM_CNT_W-1:0] cnt_reg;
    logic [31:0]                    dividend_reg;
    logic [mtbl_pkg::SIZE_W-1:0]    divisor_reg;
    logic [mtbl_pkg::SIZE_W-1:0]    rem_reg;
    logic [mtbl_pkg::SIZE_W:0]      trial;
    logic [mtbl_pkg::SIZE_W:0]      diff;
    logic [mtbl_pkg::SIZE_W-1:0]    rem_next;

    assign trial    = {rem_reg, dividend_reg[31]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign rem_next = (trial >= {1'b0, divisor_reg}) ? diff[mtbl_pkg::SIZE_W-1:0]
                                                      : trial[mtbl_pkg::SIZE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == mtbl_pkg::REM_CNT_W'(mtbl_pkg::REM_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= dividend;
            divisor_reg  <= divisor;
            rem_reg      <= '0;
        end
        else if (busy_reg)
        begin
            dividend_reg <= {dividend_reg[30:0], 1'b0};
            rem_reg      <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/mtbl_dp.sv =====
// Datapath: node store, slot memories, remainder unit and the output register.
module mtbl_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mtbl_pkg::dp_op_t            cmd,
    output mtbl_pkg::dp_status_t        status,
    input  logic [mtbl_pkg::SIZE_W-1:0] table_size,
    input  logic [31:0]                 invalid_node_id,
    input  logic                        operation,
    input  logic [31:0]                 node_id,
    input  logic [31:0]                 offset_hash,
    input  logic [31:0]                 skip_hash,
    input  logic                        last_node,
    input  logic [31:0]                 key_hash,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 chosen_node,
    output logic                        found
);

    localparam int AW = mtbl_pkg::ADDR_W;
    localparam int SW = mtbl_pkg::SIZE_W;
    localparam int NW = mtbl_pkg::NODE_IDX_W;
    localparam int CW = mtbl_pkg::NODE_CNT_W;
    localparam int FW = mtbl_pkg::FACTOR_W;

    logic          op_reg;
    logic [31:0]   id_reg;
    logic [31:0]   oh_reg;
    logic [31:0]   sh_reg;
    logic          last_reg;
    logic [31:0]   key_reg;

    logic          loading_reg;
    logic          ready_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] active_reg;
    logic [SW-1:0] v_reg;
    logic [FW-1:0] f_reg;
    logic          keep_reg;
    logic [CW-1:0] j_reg;
    logic [SW-1:0] clr_reg;
    logic [SW-1:0] fill_reg;
    logic [NW-1:0] i_reg;
    logic [AW-1:0] p_reg;

    logic [31:0]   node_list_reg [mtbl_pkg::MAX_NODES];
    logic [AW-1:0] node_offset_reg [mtbl_pkg::MAX_NODES];
    logic [AW-1:0] node_skip_reg [mtbl_pkg::MAX_NODES];
    logic [AW-1:0] node_pos_reg [mtbl_pkg::MAX_NODES];

    logic [31:0]   table_mem [mtbl_pkg::TABLE_DEPTH];
    logic          filled_mem [mtbl_pkg::TABLE_DEPTH];
    logic [31:0]   table_q_reg;
    logic          filled_q_reg;

    logic          out_valid_reg;
    logic [31:0]   out_node_reg;
    logic          out_found_reg;

    logic          rem_start;
    logic [31:0]   rem_dividend;
    logic [SW-1:0] rem_divisor;
    logic          rem_done;
    logic [SW-1:0] rem_value;

    logic [2*FW-1:0] f_sq;
    logic [SW-1:0]   step_sum;
    logic [AW-1:0]   wrap_next;
    logic [AW-1:0]   cur_skip;
    logic [NW-1:0]   i_next;

    assign f_sq      = f_reg * f_reg;
    assign cur_skip  = node_skip_reg[i_reg];
    assign step_sum  = {1'b0, p_reg} + {1'b0, cur_skip};
    assign wrap_next = (step_sum >= active_reg) ? AW'(step_sum - active_reg)
                                                : step_sum[AW-1:0];
    assign i_next    = ({1'b0, i_reg} == count_reg - 1'b1) ? '0 : i_reg + 1'b1;

    always_comb
    begin
        rem_start    = 1'b0;
        rem_dividend = oh_reg;
        rem_divisor  = active_reg;
        unique case (cmd)
            mtbl_pkg::OP_PR_DIV:
            begin
                rem_start    = 1'b1;
                rem_dividend = 32'(v_reg);
                rem_divisor  = SW'(f_reg);
            end
            mtbl_pkg::OP_OFF_DIV:
            begin
                rem_start = 1'b1;
            end
            mtbl_pkg::OP_SKIP_DIV:
            begin
                rem_start    = 1'b1;
                rem_dividend = sh_reg;
                rem_divisor  = active_reg - 1'b1;
            end
            mtbl_pkg::OP_LK_DIV:
            begin
                rem_start    = 1'b1;
                rem_dividend = key_reg;
            end
            default:
            begin
                rem_start = 1'b0;
            end
        endcase
    end

    mtbl_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (rem_dividend),
        .divisor   (rem_divisor),
        .done      (rem_done),
        .remainder (rem_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loading_reg   <= 1'b0;
            ready_reg     <= 1'b0;
            count_reg     <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd == mtbl_pkg::OP_OUT_HIT || cmd == mtbl_pkg::OP_OUT_MISS)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd)
                mtbl_pkg::OP_BATCH:
                begin
                    loading_reg <= 1'b1;
                    ready_reg   <= 1'b0;
                    count_reg   <= '0;
                end
                mtbl_pkg::OP_PR_YES:
                begin
                    active_reg <= (v_reg <= SW'(mtbl_pkg::TABLE_DEPTH)) ? v_reg
                                  : SW'(mtbl_pkg::DEFAULT_TABLE_SIZE);
                end
                mtbl_pkg::OP_PR_NO:
                begin
                    active_reg <= SW'(mtbl_pkg::DEFAULT_TABLE_SIZE);
                end
                mtbl_pkg::OP_SKIP_SAVE:
                begin
                    count_reg <= count_reg + 1'b1;
                end
                mtbl_pkg::OP_BUILD_EMPTY:
                begin
                    loading_reg <= 1'b0;
                    ready_reg   <= 1'b0;
                    count_reg   <= '0;
                end
                mtbl_pkg::OP_B_DONE:
                begin
                    loading_reg <= 1'b0;
                    ready_reg   <= 1'b1;
                    count_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            mtbl_pkg::OP_LATCH:
            begin
                op_reg   <= operation;
                id_reg   <= node_id;
                oh_reg   <= offset_hash;
                sh_reg   <= skip_hash;
                last_reg <= last_node;
                key_reg  <= key_hash;
            end
            mtbl_pkg::OP_BATCH:
            begin
                v_reg <= table_size;
                f_reg <= FW'(3);
            end
            mtbl_pkg::OP_PR_NEXT:
            begin
                f_reg <= f_reg + FW'(2);
            end
            mtbl_pkg::OP_DUP_INIT:
            begin
                keep_reg <= (id_reg != invalid_node_id);
                j_reg    <= '0;
            end
            mtbl_pkg::OP_DUP_STEP:
            begin
                if (node_list_reg[j_reg[NW-1:0]] == id_reg)
                begin
                    keep_reg <= 1'b0;
                end
                j_reg <= j_reg + 1'b1;
            end
            mtbl_pkg::OP_OFF_SAVE:
            begin
                node_offset_reg[count_reg[NW-1:0]] <= rem_value[AW-1:0];
            end
            mtbl_pkg::OP_SKIP_SAVE:
            begin
                node_skip_reg[count_reg[NW-1:0]] <= rem_value[AW-1:0] + 1'b1;
                node_list_reg[count_reg[NW-1:0]] <= id_reg;
            end
            mtbl_pkg::OP_CLR_INIT:
            begin
                clr_reg  <= '0;
                fill_reg <= '0;
                i_reg    <= '0;
                for (int k = 0; k < mtbl_pkg::MAX_NODES; k++)
                begin
                    node_pos_reg[k] <= node_offset_reg[k];
                end
            end
            mtbl_pkg::OP_CLR_STEP:
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            mtbl_pkg::OP_B_LOAD:
            begin
                p_reg <= node_pos_reg[i_reg];
            end
            mtbl_pkg::OP_B_CHK:
            begin
                if (filled_q_reg)
                begin
                    p_reg <= wrap_next;
                end
                else
                begin
                    node_pos_reg[i_reg] <= wrap_next;
                    fill_reg            <= fill_reg + 1'b1;
                    i_reg               <= i_next;
                end
            end
            mtbl_pkg::OP_OUT_HIT:
            begin
                out_node_reg  <= table_q_reg;
                out_found_reg <= 1'b1;
            end
            mtbl_pkg::OP_OUT_MISS:
            begin
                out_node_reg  <= invalid_node_id;
                out_found_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd == mtbl_pkg::OP_CLR_STEP)
        begin
            filled_mem[clr_reg[AW-1:0]] <= 1'b0;
        end
        else if (cmd == mtbl_pkg::OP_B_CHK && !filled_q_reg)
        begin
            filled_mem[p_reg] <= 1'b1;
        end
        if (cmd == mtbl_pkg::OP_B_RD)
        begin
            filled_q_reg <= filled_mem[p_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == mtbl_pkg::OP_B_CHK && !filled_q_reg)
        begin
            table_mem[p_reg] <= node_list_reg[i_reg];
        end
        if (cmd == mtbl_pkg::OP_LK_RD)
        begin
            table_q_reg <= table_mem[rem_value[AW-1:0]];
        end
    end

    always_comb
    begin
        status.is_lookup  = op_reg;
        status.last       = last_reg;
        status.loading    = loading_reg;
        status.table_ok   = ready_reg;
        status.v_lt2      = (v_reg < SW'(2));
        status.v_eq2      = (v_reg == SW'(2));
        status.v_even     = ~v_reg[0];
        status.f_sq_gt    = ((2*FW)'(v_reg) < f_sq);
        status.rem_done   = rem_done;
        status.rem_zero   = (rem_value == '0);
        status.keep       = keep_reg;
        status.j_end      = (j_reg == count_reg);
        status.count_full = (count_reg == CW'(mtbl_pkg::MAX_NODES));
        status.count_zero = (count_reg == '0);
        status.clr_last   = (clr_reg == active_reg - 1'b1);
        status.filled_hit = filled_q_reg;
        status.fill_last  = (fill_reg == active_reg - 1'b1);
        status.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign chosen_node = out_node_reg;
    assign found       = out_found_reg;

endmodule

// ===== hdl/mtbl_ctrl.sv =====
// Controller state machine that sequences loads, the prime test, the build and lookups.
module mtbl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mtbl_pkg::dp_status_t status,
    output mtbl_pkg::dp_op_t     cmd
);

    typedef enum logic [22:0] {
        S_IDLE      = 23'h000001,
        S_DISPATCH  = 23'h000002,
        S_PR_INIT   = 23'h000004,
        S_PR_TEST   = 23'h000008,
        S_PR_WAIT   = 23'h000010,
        S_DUP_INIT  = 23'h000020,
        S_DUP       = 23'h000040,
        S_ADD       = 23'h000080,
        S_OFF       = 23'h000100,
        S_OFF_WAIT  = 23'h000200,
        S_SKIP      = 23'h000400,
        S_SKIP_WAIT = 23'h000800,
        S_END       = 23'h001000,
        S_CLR       = 23'h002000,
        S_B_LOAD    = 23'h004000,
        S_B_RD      = 23'h008000,
        S_B_CHK     = 23'h010000,
        S_B_DONE    = 23'h020000,
        S_LK_DIV    = 23'h040000,
        S_LK_WAIT   = 23'h080000,
        S_LK_RD     = 23'h100000,
        S_HIT       = 23'h200000,
        S_MISS      = 23'h400000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = mtbl_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = mtbl_pkg::OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.is_lookup)
                begin
                    state_next = status.table_ok ? S_LK_DIV : S_MISS;
                end
                else if (!status.loading)
                begin
                    cmd        = mtbl_pkg::OP_BATCH;
                    state_next = S_PR_INIT;
                end
                else
                begin
                    state_next = S_DUP_INIT;
                end
            end
            S_PR_INIT:
            begin
                if (status.v_lt2)
                begin
                    cmd        = mtbl_pkg::OP_PR_NO;
                    state_next = S_DUP_INIT;
                end
                else if (status.v_eq2)
                begin
                    cmd        = mtbl_pkg::OP_PR_YES;
                    state_next = S_DUP_INIT;
                end
                else if (status.v_even)
                begin
                    cmd        = mtbl_pkg::OP_PR_NO;
                    state_next = S_DUP_INIT;
                end
                else
                begin
                    state_next = S_PR_TEST;
                end
            end
            S_PR_TEST:
            begin
                if (status.f_sq_gt)
                begin
                    cmd        = mtbl_pkg::OP_PR_YES;
                    state_next = S_DUP_INIT;
                end
                else
                begin
                    cmd        = mtbl_pkg::OP_PR_DIV;
                    state_next = S_PR_WAIT;
                end
            end
            S_PR_WAIT:
            begin
                if (status.rem_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd        = mtbl_pkg::OP_PR_NO;
                        state_next = S_DUP_INIT;
                    end
                    else
                    begin
                        cmd        = mtbl_pkg::OP_PR_NEXT;
                        state_next = S_PR_TEST;
                    end
                end
            end
            S_DUP_INIT:
            begin
                cmd        = mtbl_pkg::OP_DUP_INIT;
                state_next = S_DUP;
            end
            S_DUP:
            begin
                if (!status.keep || status.j_end)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    cmd = mtbl_pkg::OP_DUP_STEP;
                end
            end
            S_ADD:
            begin
                state_next = (status.keep && !status.count_full) ? S_OFF : S_END;
            end
            S_OFF:
            begin
                cmd        = mtbl_pkg::OP_OFF_DIV;
                state_next = S_OFF_WAIT;
            end
            S_OFF_WAIT:
            begin
                if (status.rem_done)
                begin
                    cmd        = mtbl_pkg::OP_OFF_SAVE;
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                cmd        = mtbl_pkg::OP_SKIP_DIV;
                state_next = S_SKIP_WAIT;
            end
            S_SKIP_WAIT:
            begin
                if (status.rem_done)
                begin
                    cmd        = mtbl_pkg::OP_SKIP_SAVE;
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if (!status.last)
                begin
                    state_next = S_IDLE;
                end
                else if (status.count_zero)
                begin
                    cmd        = mtbl_pkg::OP_BUILD_EMPTY;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd        = mtbl_pkg::OP_CLR_INIT;
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                cmd = mtbl_pkg::OP_CLR_STEP;
                if (status.clr_last)
                begin
                    state_next = S_B_LOAD;
                end
            end
            S_B_LOAD:
            begin
                cmd        = mtbl_pkg::OP_B_LOAD;
                state_next = S_B_RD;
            end
            S_B_RD:
            begin
                cmd        = mtbl_pkg::OP_B_RD;
                state_next = S_B_CHK;
            end
            S_B_CHK:
            begin
                cmd = mtbl_pkg::OP_B_CHK;
                if (status.filled_hit)
                begin
                    state_next = S_B_RD;
                end
                else if (status.fill_last)
                begin
                    state_next = S_B_DONE;
                end
                else
                begin
                    state_next = S_B_LOAD;
                end
            end
            S_B_DONE:
            begin
                cmd        = mtbl_pkg::OP_B_DONE;
                state_next = S_IDLE;
            end
            S_LK_DIV:
            begin
                cmd        = mtbl_pkg::OP_LK_DIV;
                state_next = S_LK_WAIT;
            end
            S_LK_WAIT:
            begin
                if (status.rem_done)
                begin
                    state_next = S_LK_RD;
                end
            end
            S_LK_RD:
            begin
                cmd        = mtbl_pkg::OP_LK_RD;
                state_next = S_HIT;
            end
            S_HIT:
            begin
                if (!status.out_busy)
                begin
                    cmd        = mtbl_pkg::OP_OUT_HIT;
                    state_next = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (!status.out_busy)
                begin
                    cmd        = mtbl_pkg::OP_OUT_MISS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/maglev_table_build_and_lookup.sv =====
// Top level of the Maglev lookup table: register port, controller and datapath.
// The block takes one beat at a time. A lookup spends most of its time in the
// bit-serial remainder unit, which reduces the key hash modulo the table size.
// A load beat runs the duplicate scan over the nodes already loaded and two
// remainders. The first load beat of a batch also tests the table size register
// for primality by trial division with the same remainder unit, one odd factor
// after another. The beat marked last then builds the table if any node was
// loaded: a pass that clears M slot flags, one per cycle, then for each slot
// claimed a load, read and check step, with a further read and check for each
// occupied slot probed. Results leave through an output register.
module maglev_table_build_and_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] node_id,
    input  logic [31:0] offset_hash,
    input  logic [31:0] skip_hash,
    input  logic        last_node,
    input  logic [31:0] key_hash,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] chosen_node,
    output logic        found
);

`include "maglev_table_build_and_lookup_defines.svh"

    logic [mtbl_pkg::SIZE_W-1:0] table_size_reg;
    logic [31:0]                 invalid_id_reg;
    logic                        cfg_write;
    mtbl_pkg::dp_op_t            cmd;
    mtbl_pkg::dp_status_t        status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= mtbl_pkg::SIZE_W'(mtbl_pkg::DEFAULT_TABLE_SIZE);
            invalid_id_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                invalid_id_reg <= pwdata;
            end
            else
            begin
                table_size_reg <= pwdata[mtbl_pkg::SIZE_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? invalid_id_reg : 32'(table_size_reg);

    mtbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mtbl_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .table_size      (table_size_reg),
        .invalid_node_id (invalid_id_reg),
        .operation       (operation),
        .node_id         (node_id),
        .offset_hash     (offset_hash),
        .skip_hash       (skip_hash),
        .last_node       (last_node),
        .key_hash        (key_hash),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_node     (chosen_node),
        .found           (found)
    );

    `MTBL_ASSERT_NEXT(a_one_beat_at_a_time, in_valid && in_ready, !in_ready, "input accepted while busy")
    `MTBL_ASSERT_NOW(a_no_result_overwrite, cmd == mtbl_pkg::OP_OUT_HIT || cmd == mtbl_pkg::OP_OUT_MISS, !status.out_busy, "pending result overwritten")
    `MTBL_ASSERT_NOW(a_lookup_needs_table, cmd == mtbl_pkg::OP_LK_DIV, status.table_ok, "lookup started without a table")
    `MTBL_ASSERT_NOW(a_build_has_nodes, cmd == mtbl_pkg::OP_B_DONE, !status.count_zero, "build finished with no nodes")

endmodule
